// ----- hdl/fhal_pkg.sv -----
package fhal_pkg;

  // Heap geometry, in 8-byte units.
  localparam int HEAP_UNITS   = 512;
  localparam int HEADER_UNITS = 3;
  localparam int UNIT_SHIFT   = 3;

  // Field and datapath widths.
  localparam int ADDR_W   = 9;   // header index into the heap
  localparam int SIZE_W   = 9;   // chunk payload size in units
  localparam int NEXT_W   = 10;  // next-header sum, can reach past the heap end
  localparam int BYTES_W  = 16;  // requested byte count
  localparam int UNITS_W  = BYTES_W + 1 - UNIT_SHIFT;  // rounded unit count
  localparam int OFF_W    = 12;  // payload byte offset
  localparam int STATUS_W = 3;
  localparam int HDR_W    = SIZE_W + 1;

  // Size of the single free chunk that covers the heap after reset.
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_UNITS - HEADER_UNITS);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE  = 3'd5;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // One input item.
  typedef struct packed {
    logic               func;
    logic [BYTES_W-1:0] request_bytes;
    logic [OFF_W-1:0]   free_offset;
    logic               free_is_null;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    payload_offset;
  } rsp_t;

  // One chunk header as held in the header memory.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              used;
  } hdr_t;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// Channel   Ports                 Direction  Transfer
// command   start, busy, req      in         taken when start is high and busy is low
// result    done, rsp             out        shown for one cycle while done is high
//
// One item at a time; each header is read from the single-port header RAM and
// then checked, so the chain walk sets the latency. Allocate checks chunks from
// the start until one fits, marks it used and, on a split, frees the rest.
// Free walks the chain to the target, then merges over the whole chain. Items
// rejected on acceptance need no header read. After reset, busy is high for one
// cycle while the first header is written. The receiver cannot stall results.
module first_fit_heap_allocator
  import fhal_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_CHK, S_A_SPLIT,
    S_F_RD, S_F_CHK,
    S_M_RD0, S_M_LD, S_M_RD, S_M_CHK
  } state_t;

  state_t              state;
  logic [UNITS_W-1:0]  units;
  logic [NEXT_W-1:0]   h;
  logic [ADDR_W-1:0]   target;
  logic [ADDR_W-1:0]   nh;
  logic [SIZE_W-1:0]   rest;
  logic [ADDR_W-1:0]   cur;
  logic [SIZE_W-1:0]   cur_size;
  logic                cur_used;
  logic [NEXT_W-1:0]   nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  hdr_t                ram_wdata;
  logic [HDR_W-1:0]    ram_rdata;
  hdr_t                rd;

  logic [BYTES_W:0]    bytes_rnd;
  logic [UNITS_W-1:0]  units_in;
  logic [ADDR_W-1:0]   free_unit;
  logic [NEXT_W-1:0]   walk_next;
  logic                fits;
  logic                split_ok;
  logic [NEXT_W-1:0]   split_nh;
  logic [SIZE_W-1:0]   split_rest;
  logic [ADDR_W-1:0]   pay_unit;
  logic [OFF_W-1:0]    pay_off;
  logic                at_target;
  logic                merge_both;
  logic [SIZE_W-1:0]   merged;
  logic [NEXT_W-1:0]   merge_next;
  logic [NEXT_W-1:0]   first_next;

  assign rd   = hdr_t'(ram_rdata);
  assign busy = (state != S_IDLE);

  // Request decode: round bytes up to units, split the free offset.
  assign bytes_rnd = {1'b0, req.request_bytes} + (BYTES_W+1)'((1 << UNIT_SHIFT) - 1);
  assign units_in  = bytes_rnd[BYTES_W:UNIT_SHIFT];
  assign free_unit = req.free_offset[OFF_W-1:UNIT_SHIFT];

  // Shared header arithmetic for the walk, the split and the merge.
  assign walk_next  = h + NEXT_W'(HEADER_UNITS) + NEXT_W'(rd.size);
  assign fits       = !rd.used && (UNITS_W'(rd.size) >= units);
  assign split_ok   = (UNITS_W+1)'(rd.size) >=
                      ((UNITS_W+1)'(units) + (UNITS_W+1)'(HEADER_UNITS + 1));
  assign split_nh   = h + NEXT_W'(HEADER_UNITS) + NEXT_W'(units[SIZE_W-1:0]);
  assign split_rest = rd.size - units[SIZE_W-1:0] - SIZE_W'(HEADER_UNITS);
  assign pay_unit   = h[ADDR_W-1:0] + ADDR_W'(HEADER_UNITS);
  assign pay_off    = {pay_unit, {UNIT_SHIFT{1'b0}}};
  assign at_target  = (h == NEXT_W'(target));
  assign merge_both = !cur_used && !rd.used;
  assign merged     = cur_size + SIZE_W'(HEADER_UNITS) + rd.size;
  assign merge_next = merge_both
                      ? NEXT_W'(cur) + NEXT_W'(HEADER_UNITS) + NEXT_W'(merged)
                      : nxt + NEXT_W'(HEADER_UNITS) + NEXT_W'(rd.size);
  assign first_next = NEXT_W'(HEADER_UNITS) + NEXT_W'(rd.size);

  // Header RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = h[ADDR_W-1:0];
    ram_wdata = '0;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = '{size: INIT_SIZE, used: 1'b0};
      end
      S_A_CHK: begin
        if (fits) begin
          ram_we    = 1'b1;
          ram_wdata = '{size: (split_ok ? units[SIZE_W-1:0] : rd.size), used: 1'b1};
        end
      end
      S_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_addr  = nh;
        ram_wdata = '{size: rest, used: 1'b0};
      end
      S_F_CHK: begin
        if (at_target && rd.used) begin
          ram_we    = 1'b1;
          ram_wdata = '{size: rd.size, used: 1'b0};
        end
      end
      S_M_RD0: ram_addr = '0;
      S_M_RD:  ram_addr = nxt[ADDR_W-1:0];
      S_M_CHK: begin
        if (merge_both) begin
          ram_we    = 1'b1;
          ram_addr  = cur;
          ram_wdata = '{size: merged, used: 1'b0};
        end
      end
      default: ;
    endcase
  end

  fhal_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_UNITS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer: chain walk, split, free check and merge pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: state <= S_IDLE;

        S_IDLE: begin
          if (start) begin
            h <= '0;
            rsp.payload_offset <= '0;
            if (req.func == FUNC_ALLOC) begin
              units <= units_in;
              if (units_in == '0) begin
                done       <= 1'b1;
                rsp.status <= ST_ZERO;
              end else begin
                state <= S_A_RD;
              end
            end else if (req.free_is_null) begin
              done       <= 1'b1;
              rsp.status <= ST_NULL;
            end else if (req.free_offset[UNIT_SHIFT-1:0] != '0 ||
                         free_unit < ADDR_W'(HEADER_UNITS)) begin
              done       <= 1'b1;
              rsp.status <= ST_INVALID;
            end else begin
              target <= free_unit - ADDR_W'(HEADER_UNITS);
              state  <= S_F_RD;
            end
          end
        end

        S_A_RD: state <= S_A_CHK;

        S_A_CHK: begin
          if (fits) begin
            if (split_ok && split_nh < NEXT_W'(HEAP_UNITS)) begin
              nh    <= split_nh[ADDR_W-1:0];
              rest  <= split_rest;
              state <= S_A_SPLIT;
            end else begin
              done               <= 1'b1;
              rsp.status         <= ST_OK;
              rsp.payload_offset <= pay_off;
              state              <= S_IDLE;
            end
          end else if (walk_next >= NEXT_W'(HEAP_UNITS)) begin
            done       <= 1'b1;
            rsp.status <= ST_NOSPACE;
            state      <= S_IDLE;
          end else begin
            h     <= walk_next;
            state <= S_A_RD;
          end
        end

        S_A_SPLIT: begin
          done               <= 1'b1;
          rsp.status         <= ST_OK;
          rsp.payload_offset <= pay_off;
          state              <= S_IDLE;
        end

        S_F_RD: state <= S_F_CHK;

        S_F_CHK: begin
          if (at_target) begin
            if (!rd.used) begin
              done       <= 1'b1;
              rsp.status <= ST_DOUBLE;
              state      <= S_IDLE;
            end else begin
              state <= S_M_RD0;
            end
          end else if (h > NEXT_W'(target) || walk_next >= NEXT_W'(HEAP_UNITS)) begin
            done       <= 1'b1;
            rsp.status <= ST_INVALID;
            state      <= S_IDLE;
          end else begin
            h     <= walk_next;
            state <= S_F_RD;
          end
        end

        S_M_RD0: state <= S_M_LD;

        // The first chunk becomes the current chunk of the merge pass.
        S_M_LD: begin
          cur      <= '0;
          cur_size <= rd.size;
          cur_used <= rd.used;
          nxt      <= first_next;
          if (first_next >= NEXT_W'(HEAP_UNITS)) begin
            done       <= 1'b1;
            rsp.status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            state <= S_M_RD;
          end
        end

        S_M_RD: state <= S_M_CHK;

        // Absorb the next chunk when both are free, else step forward.
        S_M_CHK: begin
          if (merge_both) begin
            cur_size <= merged;
          end else begin
            cur      <= nxt[ADDR_W-1:0];
            cur_size <= rd.size;
            cur_used <= rd.used;
          end
          nxt <= merge_next;
          if (merge_next >= NEXT_W'(HEAP_UNITS)) begin
            done       <= 1'b1;
            rsp.status <= ST_OK;
            state      <= S_IDLE;
          end else begin
            state <= S_M_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither finished nor held the block busy");

  // Every result carries a defined status code.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status <= ST_DOUBLE))
    else $error("result status out of range");

  // Failed results carry a zero offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.payload_offset == '0))
    else $error("nonzero offset on a failed result");

  // A header is never written beyond the end of the heap by a split.
  a_split_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPLIT) |-> ($past(split_nh) < NEXT_W'(HEAP_UNITS)))
    else $error("split header placed outside the heap");

endmodule

// ----- hdl/fhal_ram.sv -----
module fhal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read of the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
